// ===== src/rbs_pkg.sv =====
`default_nettype none

package rbs_pkg;

    // Default coordinate format: signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Ray and box are three-dimensional
    localparam int NUM_AXES = 3;

endpackage

`default_nettype wire

// ===== src/rbs_div.sv =====
`default_nettype none

// Pipelined signed fixed-point divider, one quotient bit per stage.
// quot = sign * min(floor(num * 2^F / den), 2^(W-1)-1).
module rbs_div #(
    parameter int W = rbs_pkg::COORD_WIDTH_DEF,
    parameter int F = rbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [W:0]          num,   // numerator magnitude
    input  wire logic [W-1:0]        den,   // denominator magnitude
    input  wire logic                neg,   // result sign
    output logic signed [W-1:0]      quot
);

    localparam int QW = W - 1;
    localparam int RW = W + 1 + F;
    localparam int CW = (RW > 2 * W - 1) ? RW : 2 * W - 1;

    logic [CW-1:0] r_reg   [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [W-1:0]  d_reg   [QW];
    logic          neg_reg [QW];
    logic          ovf_reg [QW];

    logic [CW-1:0] dividend;
    logic [CW-1:0] limit;
    logic          ovf_in;

    // Quotient overflows when num * 2^F >= den * 2^(W-1)
    assign dividend = CW'(num) << F;
    assign limit    = CW'(den) << QW;
    assign ovf_in   = (dividend >= limit);

    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int BIT = QW - 1 - j;

        logic [CW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [W-1:0]  d_in;
        logic          neg_in;
        logic          ovf_cur;
        logic [CW-1:0] dsh;
        logic          ge;
        logic [CW-1:0] r_next;
        logic [QW-1:0] q_next;

        if (j == 0) begin : g_first
            assign r_in    = dividend;
            assign q_in    = '0;
            assign d_in    = den;
            assign neg_in  = neg;
            assign ovf_cur = ovf_in;
        end else begin : g_rest
            assign r_in    = r_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign d_in    = d_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign ovf_cur = ovf_reg[j-1];
        end

        // Restoring step for one quotient bit
        always_comb
        begin
            dsh         = CW'(d_in) << BIT;
            ge          = (r_in >= dsh);
            r_next      = ge ? (r_in - dsh) : r_in;
            q_next      = q_in;
            q_next[BIT] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= r_next;
                q_reg[j]   <= q_next;
                d_reg[j]   <= d_in;
                neg_reg[j] <= neg_in;
                ovf_reg[j] <= ovf_cur;
            end
        end
    end

    // Saturate and apply sign
    logic [W-1:0] sat;
    assign sat = ovf_reg[QW-1] ? {1'b0, {QW{1'b1}}} : {1'b0, q_reg[QW-1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot <= neg_reg[QW-1] ? -$signed(sat) : $signed(sat);
        end
    end

endmodule

`default_nettype wire

// ===== src/ray_box_slab_intersection.sv =====
`default_nettype none

// Channel | Dir | Fields
// s_axis  | in  | tdata: origin_x/y/z, dir_x/y/z, box_min_x/y/z, box_max_x/y/z
// m_axis  | out | tdata: hit
//
// One ray/box pair per cycle sustained unless the output stalls; most depth
// is in the bit-per-stage dividers (six lanes, COORD_WIDTH stages each).
// rst_n clears all valid bits, those of the output and skid registers too.
// A stalled output parks one result in a skid register; the pipeline then
// freezes and s_tready drops until the skid register drains.
module ray_box_slab_intersection #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, pad
    input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // hit, pad
    output logic [7:0]               m_tdata
);

    localparam int W  = COORD_WIDTH;
    localparam int NA = rbs_pkg::NUM_AXES;

    logic skid_valid_reg;
    logic en;
    assign en = !skid_valid_reg;

    // ---- stage 1: input register
    logic                v1_reg;
    logic signed [W-1:0] o1_reg  [NA];
    logic signed [W-1:0] d1_reg  [NA];
    logic signed [W-1:0] lo1_reg [NA];
    logic signed [W-1:0] hi1_reg [NA];

    assign s_tready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en && s_tvalid)
        begin
            for (int a = 0; a < NA; a++)
            begin
                o1_reg[a]  <= $signed(s_tdata[a*W +: W]);
                d1_reg[a]  <= $signed(s_tdata[(3+a)*W +: W]);
                lo1_reg[a] <= $signed(s_tdata[(6+a)*W +: W]);
                hi1_reg[a] <= $signed(s_tdata[(9+a)*W +: W]);
            end
        end
    end

    // ---- stage 2: slab offsets, magnitudes, signs, zero-axis and in-slab tests
    logic          v2_reg;
    logic [W:0]    mlo2_reg  [NA];
    logic [W:0]    mhi2_reg  [NA];
    logic [W-1:0]  md2_reg   [NA];
    logic          nlo2_reg  [NA];
    logic          nhi2_reg  [NA];
    logic          zero2_reg [NA];
    logic          out2_reg  [NA];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    for (genvar a = 0; a < NA; a++) begin : g_prep
        logic signed [W:0] dlo;
        logic signed [W:0] dhi;
        logic              dneg;
        logic              in_slab;

        always_comb
        begin
            dlo     = (W+1)'(lo1_reg[a]) - (W+1)'(o1_reg[a]);
            dhi     = (W+1)'(hi1_reg[a]) - (W+1)'(o1_reg[a]);
            dneg    = d1_reg[a][W-1];
            in_slab = ((lo1_reg[a] <= o1_reg[a]) && (o1_reg[a] <= hi1_reg[a])) ||
                      ((hi1_reg[a] <= o1_reg[a]) && (o1_reg[a] <= lo1_reg[a]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mlo2_reg[a]  <= dlo[W] ? (W+1)'(0) - dlo : dlo;
                mhi2_reg[a]  <= dhi[W] ? (W+1)'(0) - dhi : dhi;
                md2_reg[a]   <= dneg ? W'(0) - d1_reg[a] : d1_reg[a];
                nlo2_reg[a]  <= dlo[W] ^ dneg;
                nhi2_reg[a]  <= dhi[W] ^ dneg;
                zero2_reg[a] <= (d1_reg[a] == '0);
                out2_reg[a]  <= !in_slab;
            end
        end
    end

    // ---- divider lanes, with side information delayed to match
    logic signed [W-1:0] t1 [NA];
    logic signed [W-1:0] t2 [NA];

    for (genvar a = 0; a < NA; a++) begin : g_div
        rbs_div #(.W(W), .F(FRAC_BITS)) u_div_lo (
            .clk  (clk),
            .en   (en),
            .num  (mlo2_reg[a]),
            .den  (md2_reg[a]),
            .neg  (nlo2_reg[a]),
            .quot (t1[a])
        );
        rbs_div #(.W(W), .F(FRAC_BITS)) u_div_hi (
            .clk  (clk),
            .en   (en),
            .num  (mhi2_reg[a]),
            .den  (md2_reg[a]),
            .neg  (nhi2_reg[a]),
            .quot (t2[a])
        );
    end

    logic [W-1:0]    vd_reg;
    logic [NA-1:0]   zd_reg [W];
    logic [NA-1:0]   od_reg [W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else if (en)
            vd_reg <= {vd_reg[W-2:0], v2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NA; a++)
            begin
                zd_reg[0][a] <= zero2_reg[a];
                od_reg[0][a] <= out2_reg[a];
            end
            for (int k = 1; k < W; k++)
            begin
                zd_reg[k] <= zd_reg[k-1];
                od_reg[k] <= od_reg[k-1];
            end
        end
    end

    // ---- stage A: per-axis entry/exit, open bounds on zero axes
    localparam logic signed [W:0] T_LOW  = {2'b11, {(W-1){1'b0}}};
    localparam logic signed [W:0] T_HIGH = {2'b01, {(W-1){1'b0}}};

    logic                va_reg;
    logic                missa_reg;
    logic signed [W:0]   tna_reg [NA];
    logic signed [W:0]   txa_reg [NA];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= vd_reg[W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            missa_reg <= |(zd_reg[W-1] & od_reg[W-1]);
            for (int a = 0; a < NA; a++)
            begin
                if (zd_reg[W-1][a])
                begin
                    tna_reg[a] <= T_LOW;
                    txa_reg[a] <= T_HIGH;
                end
                else if (t1[a] < t2[a])
                begin
                    tna_reg[a] <= (W+1)'(t1[a]);
                    txa_reg[a] <= (W+1)'(t2[a]);
                end
                else
                begin
                    tna_reg[a] <= (W+1)'(t2[a]);
                    txa_reg[a] <= (W+1)'(t1[a]);
                end
            end
        end
    end

    // ---- stage B: overall entry (max) and exit (min)
    logic              vb_reg;
    logic              missb_reg;
    logic signed [W:0] entb_reg;
    logic signed [W:0] extb_reg;
    logic signed [W:0] ent_m;
    logic signed [W:0] ext_m;

    always_comb
    begin
        ent_m = tna_reg[0];
        ext_m = txa_reg[0];
        for (int a = 1; a < NA; a++)
        begin
            if (tna_reg[a] > ent_m)
                ent_m = tna_reg[a];
            if (txa_reg[a] < ext_m)
                ext_m = txa_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            missb_reg <= missa_reg;
            entb_reg  <= ent_m;
            extb_reg  <= ext_m;
        end
    end

    // ---- hit decision and output with skid register
    logic p_valid;
    logic p_hit;
    assign p_valid = vb_reg;
    assign p_hit   = !missb_reg && !extb_reg[W] && (entb_reg <= extb_reg);

    logic out_valid_reg;
    logic out_hit_reg;
    logic skid_hit_reg;
    logic out_fire;

    assign out_fire = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (p_valid)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_hit_reg <= skid_hit_reg;
        end
        else if (p_valid)
        begin
            if (out_valid_reg && !out_fire)
                skid_hit_reg <= p_hit;
            else
                out_hit_reg <= p_hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_hit_reg};

    // ---- assertions
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted transfer did not enter the pipeline");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && $past(!en)) |-> ($stable(vb_reg) && $stable(vd_reg)))
        else $error("pipeline moved while stalled");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (en && p_valid && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result dropped on output stall");

endmodule

`default_nettype wire

// ===== test/slab_checker.sv =====
`default_nettype none

// Watches both channels, predicts the hit flag of every accepted ray/box pair
// and compares it with the results in order.
module slab_checker #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    input  wire logic                                  s_tready,
    input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    input  wire logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic [7:0]                            m_tdata,
    output int                                         fail_count,
    output int                                         pending,
    output int                                         hits_seen,
    output int                                         results_seen
);

    localparam int W = COORD_WIDTH;
    localparam logic signed [W+1:0] T_SAT = (1 <<< (W-1)) - 1;

    bit expected_hits[$];

    // Truncated, saturated fixed-point quotient of the slab distance
    function automatic logic signed [W+1:0] slab_quotient(
        input logic signed [W+1:0] num, input logic signed [W+1:0] den);
        logic [2*W+FRAC_BITS+2:0] mn, md, q;
        logic signed [W+1:0] res;
        begin
            mn = num < 0 ? -num : num;
            md = den < 0 ? -den : den;
            q = (mn << FRAC_BITS) / md;
            if (q > T_SAT) q = T_SAT;
            res = q[W+1:0];
            if ((num < 0) != (den < 0)) res = -res;
            return res;
        end
    endfunction

    function automatic bit predict_hit(input logic [((12*W+7)/8)*8-1:0] d);
        logic signed [W+1:0] o, dv, lo, hi, t1, t2, tn, tx, entry, exitd;
        bit miss;
        begin
            entry = -T_SAT - 1;
            exitd = T_SAT + 1;
            miss = 0;
            for (int a = 0; a < 3; a++)
            begin
                o  = $signed(d[a*W +: W]);
                dv = $signed(d[(3+a)*W +: W]);
                lo = $signed(d[(6+a)*W +: W]);
                hi = $signed(d[(9+a)*W +: W]);
                if (dv == 0)
                begin
                    if (!((lo <= o && o <= hi) || (hi <= o && o <= lo))) miss = 1;
                end
                else
                begin
                    t1 = slab_quotient(lo - o, dv);
                    t2 = slab_quotient(hi - o, dv);
                    tn = t1 < t2 ? t1 : t2;
                    tx = t1 < t2 ? t2 : t1;
                    if (tn > entry) entry = tn;
                    if (tx < exitd) exitd = tx;
                end
            end
            return !miss && exitd >= 0 && entry <= exitd;
        end
    endfunction

    // Sample transfers at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_hits.push_back(predict_hit(s_tdata));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tdata[0]) hits_seen++;
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual hit=%0d",
                             $time, m_tdata[0]);
                    fail_count++;
                end
                else if (expected_hits[0] != m_tdata[0])
                begin
                    $display("%0t: hit mismatch, expected %0d, actual %0d",
                             $time, expected_hits[0], m_tdata[0]);
                    fail_count++;
                    void'(expected_hits.pop_front());
                end
                else
                    void'(expected_hits.pop_front());
            end
        end
        pending = expected_hits.size();
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;

    localparam int W  = rbs_pkg::COORD_WIDTH_DEF;
    localparam int DW = ((12*W+7)/8)*8;
    localparam int N_RANDOM = 1200;
    localparam int LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [7:0] m_tdata;
    int fail_count, pending, hits_seen, results_seen;
    int cycles = 0;
    bit hold_off = 0;

    always #4 clk = ~clk;

    ray_box_slab_intersection u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    slab_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending),
        .hits_seen(hits_seen), .results_seen(results_seen)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // Coordinates mostly small, sometimes extreme or fully random
    function automatic logic [W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3, 4: return $urandom();
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_ray();
        logic [DW-1:0] d;
        logic [W-1:0] o, lo, hi;
        begin
            d = '0;
            for (int i = 0; i < 12; i++) d[i*W +: W] = rand_coord();
            // Mostly well formed: box ordered, origin near it, direction toward it
            if ($urandom_range(0, 3) != 0)
                for (int a = 0; a < 3; a++)
                begin
                    lo = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
                    hi = lo + $urandom_range(1, 32'h0010_0000);
                    o = lo - $urandom_range(0, 32'h0020_0000);
                    d[(6+a)*W +: W] = lo;
                    d[(9+a)*W +: W] = hi;
                    d[a*W +: W] = o;
                    d[(3+a)*W +: W] = ($urandom_range(0, 7) == 0) ? '0 :
                                      $urandom_range(1, 32'h0002_0000);
                end
            return d;
        end
    endfunction

    // Offer one item right away and hold it until transferred
    task automatic send_now(input logic [DW-1:0] d);
        begin
            s_tvalid <= 1;
            s_tdata <= d;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
        end
    endtask

    // Offer one item after a random idle gap
    task automatic send_item(input logic [DW-1:0] d);
        int g;
        begin
            g = gap_len();
            if (g > 0)
            begin
                s_tvalid <= 0;
                repeat (g) @(posedge clk);
            end
            send_now(d);
        end
    endtask

    // Build a directed item from per-axis values
    function automatic logic [DW-1:0] ray_of(input logic [W-1:0] o, input logic [W-1:0] dv,
                                             input logic [W-1:0] lo, input logic [W-1:0] hi);
        logic [DW-1:0] d;
        begin
            d = '0;
            for (int a = 0; a < 3; a++)
            begin
                d[a*W +: W] = o; d[(3+a)*W +: W] = dv;
                d[(6+a)*W +: W] = lo; d[(9+a)*W +: W] = hi;
            end
            return d;
        end
    endfunction

    // Receiver: random stalls, plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(0, 9) < 7);
    end

    initial
    begin
        int hold;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
        hold_off = 0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [DW-1:0] d;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: hits, misses, zero directions, swapped corners, extremes
        send_item(ray_of(32'hfff0_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
        send_item(ray_of(32'h0010_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
        send_item(ray_of(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000));
        send_item(ray_of(32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000));
        send_item(ray_of(32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000));
        send_item(ray_of(32'hfff0_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000));
        send_item(ray_of(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000));
        send_item(ray_of(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
        send_item(ray_of(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_item(ray_of(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_item(ray_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_item(ray_of(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000));
        send_item({DW{1'b1}});
        send_item('0);
        d = ray_of(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
        d[4*W +: W] = '0;
        send_item(d);
        // Random, with a gap-free burst to fill the pipeline
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i >= 200 && i < 500)
                send_now(rand_ray());
            else
                send_item(rand_ray());
        end
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (W + 20) @(posedge clk);
        $display("Covered %0d results (%0d hits): directed edge cases, random rays,",
                 results_seen, hits_seen);
        $display("random stalls on both sides and one long output hold-off.");
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
